>>> sv/bmk_pkg.sv
// Shared types and constants for the bounded min-k key set.
package bmk_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int KEY_W       = 64;
  localparam int LIMIT_W     = 7;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int OUT_CNT_W   = 7;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

  typedef logic signed [KEY_W-1:0] key_t;

  typedef enum logic [1:0] {
    OUT_INSERTED  = 2'd0,
    OUT_DUPLICATE = 2'd1,
    OUT_EVICTED   = 2'd2,
    OUT_DROPPED   = 2'd3
  } outcome_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_EVICT
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_e;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic     capture;
    cell_op_e op;
    key_t     key;
  } cell_cmd_t;

  // summary of the chain back to the controller
  typedef struct packed {
    logic dup;
    logic top_vld;
    logic top_below;
    key_t top_key;
  } chain_stat_t;

endpackage

>>> sv/bmk_cell.sv
// One storage cell of the sorted key chain with its compare flags.
module bmk_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bmk_pkg::cell_cmd_t cmd_i,
  input  bmk_pkg::key_t    up_key_i,
  input  logic             up_vld_i,
  input  logic             up_below_i,
  input  bmk_pkg::key_t    dn_key_i,
  input  logic             dn_above_i,
  output bmk_pkg::key_t    key_o,
  output logic             vld_o,
  output logic             below_o,
  output logic             above_o,
  output logic             eq_o
);
  import bmk_pkg::*;

  key_t key_q, key_d;
  logic vld_q, vld_d;
  logic below_q, above_q, eq_q;

  // hand keys to or take keys from the neighbors
  always_comb begin
    key_d = key_q;
    vld_d = vld_q;
    case (cmd_i.op)
      OP_INSERT: begin
        if (up_below_i) begin
          key_d = up_key_i;
          vld_d = up_vld_i;
        end else if (below_q) begin
          key_d = cmd_i.key;
          vld_d = 1'b1;
        end
      end
      OP_EVICT: begin
        if (dn_above_i) begin
          key_d = dn_key_i;
        end else if (above_q) begin
          key_d = cmd_i.key;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  // capture the compare against the offered key; an empty cell counts as smaller
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      below_q <= !vld_q || (key_q < cmd_i.key);
      above_q <= vld_q && (key_q > cmd_i.key);
      eq_q    <= vld_q && (key_q == cmd_i.key);
    end
  end

  assign key_o   = key_q;
  assign vld_o   = vld_q;
  assign below_o = below_q;
  assign above_o = above_q;
  assign eq_o    = eq_q;

endmodule

>>> sv/bmk_chain.sv
// Row of sorted key cells, largest key held at the top end.
module bmk_chain (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bmk_pkg::cell_cmd_t   cmd_i,
  output bmk_pkg::chain_stat_t stat_o
);
  import bmk_pkg::*;

  key_t key_w   [MAX_ENTRIES];
  logic vld_w   [MAX_ENTRIES];
  logic below_w [MAX_ENTRIES];
  logic above_w [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] eq_w;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    key_t up_key, dn_key;
    logic up_vld, up_below, dn_above;

    // tie off the ends of the row
    if (i == MAX_ENTRIES - 1) begin : g_top
      assign up_key   = '0;
      assign up_vld   = 1'b0;
      assign up_below = 1'b0;
    end else begin : g_up
      assign up_key   = key_w[i+1];
      assign up_vld   = vld_w[i+1];
      assign up_below = below_w[i+1];
    end
    if (i == 0) begin : g_bot
      assign dn_key   = '0;
      assign dn_above = 1'b0;
    end else begin : g_dn
      assign dn_key   = key_w[i-1];
      assign dn_above = above_w[i-1];
    end

    bmk_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd_i),
      .up_key_i   (up_key),
      .up_vld_i   (up_vld),
      .up_below_i (up_below),
      .dn_key_i   (dn_key),
      .dn_above_i (dn_above),
      .key_o      (key_w[i]),
      .vld_o      (vld_w[i]),
      .below_o    (below_w[i]),
      .above_o    (above_w[i]),
      .eq_o       (eq_w[i])
    );
  end

  // reduce the registered match flags and report the top cell
  assign stat_o.dup       = |eq_w;
  assign stat_o.top_vld   = vld_w[MAX_ENTRIES-1];
  assign stat_o.top_below = below_w[MAX_ENTRIES-1];
  assign stat_o.top_key   = key_w[MAX_ENTRIES-1];

endmodule

>>> sv/bounded_min_k_key_set.sv
// Top level: controller, limit register and result register around the key chain.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------------
//  in      | input     | in_valid_i / in_stall_o   | offered_key_i
//  out     | output    | out_valid_o / out_stall_i | outcome_o evicted_key_o kept_count_o
//          |           |                           | largest_kept_o
//  cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_data_i (keep_limit)
//
// Each key passes through accept, a parallel compare in every cell, then
// one shift of the cell row that inserts or evicts. The next key is accepted
// only after the shift step, once the controller is back in idle.
// Reset empties the row at once (cell valid bits) and sets the limit to 64.
// A result waiting under out_stall_i does not block the next transfer in; only
// the shift step waits until the result register is free.
module bounded_min_k_key_set (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  bmk_pkg::key_t                   offered_key_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      outcome_o,
  output bmk_pkg::key_t                   evicted_key_o,
  output logic [bmk_pkg::OUT_CNT_W-1:0]   kept_count_o,
  output bmk_pkg::key_t                   largest_kept_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bmk_pkg::LIMIT_W-1:0]     cfg_data_i
);
  import bmk_pkg::*;

  localparam int LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(MAX_ENTRIES);

  state_e             state_q, state_d;
  key_t               key_q;
  logic [LIMIT_W-1:0] limit_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               out_vld_q, out_vld_d;
  outcome_e           outcome_q, outcome_d;
  key_t               evicted_q, evicted_d;
  logic               load_out;
  logic [LIM_W-1:0]   eff_limit;
  logic               full;
  cell_cmd_t          cmd;
  chain_stat_t        stat;

  // clamp the limit to the row length
  assign eff_limit = (LIM_W'(limit_q) > MAX_LIM) ? MAX_LIM : LIM_W'(limit_q);
  assign full      = LIM_W'(count_q) >= eff_limit;

  // sequence one key through compare and shift
  always_comb begin
    state_d     = state_q;
    in_stall_o  = 1'b1;
    cmd.capture = 1'b0;
    cmd.op      = OP_HOLD;
    cmd.key     = key_q;
    load_out    = 1'b0;
    count_d     = count_q;
    outcome_d   = outcome_q;
    evicted_d   = evicted_q;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd.capture = 1'b1;
        state_d     = ST_UPD;
      end
      ST_UPD: begin
        if (!out_vld_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
          if (stat.dup) begin
            outcome_d = OUT_DUPLICATE;
            evicted_d = '0;
          end else if (full && stat.top_below) begin
            outcome_d = OUT_DROPPED;
            evicted_d = key_q;
          end else if (full) begin
            outcome_d = OUT_EVICTED;
            evicted_d = stat.top_key;
            cmd.op    = OP_EVICT;
          end else begin
            outcome_d = OUT_INSERTED;
            evicted_d = '0;
            cmd.op    = OP_INSERT;
            count_d   = CNT_W'(count_q + 1'b1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // hold the result until the transfer out
  always_comb begin
    out_vld_d = out_vld_q;
    if (load_out) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      out_vld_q <= 1'b0;
      limit_q   <= LIMIT_RESET;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      out_vld_q <= out_vld_d;
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      key_q <= offered_key_i;
    end
    if (load_out) begin
      outcome_q <= outcome_d;
      evicted_q <= evicted_d;
    end
  end

  bmk_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

  // count and top key only change when the result register reloads
  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_vld_q;
  assign outcome_o      = outcome_q;
  assign evicted_key_o  = evicted_q;
  assign kept_count_o   = OUT_CNT_W'(count_q);
  assign largest_kept_o = stat.top_vld ? stat.top_key : '0;

endmodule

>>> sv/bmk_checker.sv
// Port-level assertions for the key set, bound to the top level.
module bmk_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_o,
  input  bmk_pkg::key_t                   offered_key_i,
  input  logic                            out_valid_o,
  input  logic                            out_stall_i,
  input  logic [1:0]                      outcome_o,
  input  bmk_pkg::key_t                   evicted_key_o,
  input  logic [bmk_pkg::OUT_CNT_W-1:0]   kept_count_o,
  input  bmk_pkg::key_t                   largest_kept_o,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_o,
  input  logic [bmk_pkg::LIMIT_W-1:0]     cfg_data_i
);
  import bmk_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(outcome_o)
      && $stable(evicted_key_o) && $stable(kept_count_o) && $stable(largest_kept_o))
    else $error("stalled result changed");

  // one key at a time: busy right after a transfer in
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a key is in flight");

  // duplicates and plain inserts evict nothing
  a_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (outcome_o == OUT_DUPLICATE || outcome_o == OUT_INSERTED)
      |-> evicted_key_o == '0)
    else $error("eviction key on a non-evicting outcome");

  // an insert or eviction leaves a non-empty set
  a_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (outcome_o == OUT_INSERTED || outcome_o == OUT_EVICTED)
      |-> kept_count_o != '0)
    else $error("empty set after insertion");

  // a dropped key is never below the kept top
  a_drop_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && outcome_o == OUT_DROPPED && kept_count_o != '0
      |-> evicted_key_o > largest_kept_o)
    else $error("dropped key smaller than largest kept");

endmodule

bind bounded_min_k_key_set bmk_checker u_bmk_checker (.*);
